>>> rtl/core/kpd_pkg.sv
// Shared constants for the key pair distance block.
package kpd_pkg;

   // Width of the distance result; wider roots are truncated to this width.
   localparam int DIST_BITS = 15;

endpackage

>>> rtl/core/kpd_geom.sv
// Front stages: rectangle centres, centre differences, squares and the radicand.
module kpd_geom
   import kpd_pkg::*;
#(
   parameter int COORD_BITS = 14,
   parameter int INDEX_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [INDEX_BITS-1:0]     first_index,
   input  logic [COORD_BITS-1:0]     first_left,
   input  logic [COORD_BITS-1:0]     first_top,
   input  logic [COORD_BITS-1:0]     first_right,
   input  logic [COORD_BITS-1:0]     first_bottom,
   input  logic [INDEX_BITS-1:0]     second_index,
   input  logic [COORD_BITS-1:0]     second_left,
   input  logic [COORD_BITS-1:0]     second_top,
   input  logic [COORD_BITS-1:0]     second_right,
   input  logic [COORD_BITS-1:0]     second_bottom,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [2*COORD_BITS+1:0]   out_radicand
);

   localparam int SUM_BITS = COORD_BITS + 1;
   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int RAD_BITS = 2 * COORD_BITS + 2;

   // Stage one: centres and the same-key flag.
   logic                  v1_ff;
   logic                  same1_ff;
   logic [COORD_BITS-1:0] xa1_ff, ya1_ff, xb1_ff, yb1_ff;
   logic [SUM_BITS-1:0]   sxa_in, sya_in, sxb_in, syb_in;

   // Stage two: absolute differences.
   logic                  v2_ff;
   logic                  same2_ff;
   logic [COORD_BITS-1:0] dx2_ff, dy2_ff;
   logic [COORD_BITS-1:0] dx_in, dy_in;

   // Stage three: squares.
   logic                  v3_ff;
   logic                  same3_ff;
   logic [SQ_BITS-1:0]    sqx3_ff, sqy3_ff;
   logic [SQ_BITS-1:0]    sqx_in, sqy_in;

   // Stage four: radicand, forced to zero for the same key.
   logic                  v4_ff;
   logic [RAD_BITS-1:0]   rad4_ff;
   logic [RAD_BITS-1:0]   rad_in;

   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign sxa_in = SUM_BITS'(first_left) + SUM_BITS'(first_right);
   assign sya_in = SUM_BITS'(first_top) + SUM_BITS'(first_bottom);
   assign sxb_in = SUM_BITS'(second_left) + SUM_BITS'(second_right);
   assign syb_in = SUM_BITS'(second_top) + SUM_BITS'(second_bottom);

   assign dx_in = (xa1_ff >= xb1_ff) ? (xa1_ff - xb1_ff) : (xb1_ff - xa1_ff);
   assign dy_in = (ya1_ff >= yb1_ff) ? (ya1_ff - yb1_ff) : (yb1_ff - ya1_ff);

   assign sqx_in = SQ_BITS'(dx2_ff) * SQ_BITS'(dx2_ff);
   assign sqy_in = SQ_BITS'(dy2_ff) * SQ_BITS'(dy2_ff);

   assign rad_in = same3_ff ? '0 : (RAD_BITS'(sqx3_ff) + RAD_BITS'(sqy3_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         same1_ff <= (first_index == second_index);
         xa1_ff   <= sxa_in[SUM_BITS-1:1];
         ya1_ff   <= sya_in[SUM_BITS-1:1];
         xb1_ff   <= sxb_in[SUM_BITS-1:1];
         yb1_ff   <= syb_in[SUM_BITS-1:1];
      end
      if (rdy2) begin
         same2_ff <= same1_ff;
         dx2_ff   <= dx_in;
         dy2_ff   <= dy_in;
      end
      if (rdy3) begin
         same3_ff <= same2_ff;
         sqx3_ff  <= sqx_in;
         sqy3_ff  <= sqy_in;
      end
      if (rdy4) begin
         rad4_ff <= rad_in;
      end
   end

   assign out_valid    = v4_ff;
   assign out_radicand = rad4_ff;

endmodule

>>> rtl/core/kpd_sqrt.sv
// Pipelined integer square root, one root bit resolved per stage.
module kpd_sqrt
   import kpd_pkg::*;
#(
   parameter int ROOT_BITS = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [2*ROOT_BITS-1:0]   in_radicand,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [DIST_BITS-1:0]     out_root
);

   localparam int RAD_BITS = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 2;

   logic                valid_ff [ROOT_BITS];
   logic [RAD_BITS-1:0] rad_ff   [ROOT_BITS];
   logic [REM_BITS-1:0] rem_ff   [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [ROOT_BITS-1:0] adv;

   genvar k;
   generate
      for (k = 0; k < ROOT_BITS; k++) begin : g_stage
         logic                 prev_valid;
         logic [RAD_BITS-1:0]  prev_rad;
         logic [REM_BITS-1:0]  prev_rem;
         logic [ROOT_BITS-1:0] prev_root;
         logic [REM_BITS-1:0]  shifted;
         logic [REM_BITS-1:0]  trial;
         logic                 fits;
         logic [RAD_BITS-1:0]  rad_in;
         logic [REM_BITS-1:0]  rem_in;
         logic [ROOT_BITS-1:0] root_in;

         if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rad   = in_radicand;
            assign prev_rem   = '0;
            assign prev_root  = '0;
         end else begin : g_next
            assign prev_valid = valid_ff[k-1];
            assign prev_rad   = rad_ff[k-1];
            assign prev_rem   = rem_ff[k-1];
            assign prev_root  = root_ff[k-1];
         end

         if (k == ROOT_BITS - 1) begin : g_last
            assign adv[k] = !valid_ff[k] || out_ready;
         end else begin : g_mid
            assign adv[k] = !valid_ff[k] || adv[k+1];
         end

         // Bring down the next two radicand bits and try root*4+1 against them.
         always_comb begin
            shifted = {prev_rem[REM_BITS-3:0], prev_rad[RAD_BITS-1:RAD_BITS-2]};
            trial   = {prev_root, 2'b01};
            fits    = (shifted >= trial);
            rem_in  = fits ? (shifted - trial) : shifted;
            root_in = {prev_root[ROOT_BITS-2:0], fits};
            rad_in  = {prev_rad[RAD_BITS-3:0], 2'b00};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (adv[k]) begin
               valid_ff[k] <= prev_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (adv[k]) begin
               rad_ff[k]  <= rad_in;
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
            end
         end
      end
   endgenerate

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_root  = DIST_BITS'(root_ff[ROOT_BITS-1]);

endmodule

>>> rtl/core/key_pair_distance.sv
// Top level: distance between the centres of two key rectangles.
//
//  channel | ports           | direction | carries
//  --------+-----------------+-----------+-------------------------------------------
//  request | req_valid/ready | in        | two key indices and two rectangles
//  result  | rsp_valid/ready | out       | floor of the distance between the centres
//
// One transaction is accepted per cycle when the result side keeps up.
// The pipeline has four geometry stages, then one square root stage per root
// bit. Reset clears only the stage valid bits.
// A stalled result holds in the last stage; ready ripples back stage by stage,
// so empty stages keep filling while the output waits.
module key_pair_distance
   import kpd_pkg::*;
#(
   parameter int COORD_BITS = 14,
   parameter int INDEX_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [INDEX_BITS-1:0] req_first_index,
   input  logic [COORD_BITS-1:0] req_first_left,
   input  logic [COORD_BITS-1:0] req_first_top,
   input  logic [COORD_BITS-1:0] req_first_right,
   input  logic [COORD_BITS-1:0] req_first_bottom,
   input  logic [INDEX_BITS-1:0] req_second_index,
   input  logic [COORD_BITS-1:0] req_second_left,
   input  logic [COORD_BITS-1:0] req_second_top,
   input  logic [COORD_BITS-1:0] req_second_right,
   input  logic [COORD_BITS-1:0] req_second_bottom,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DIST_BITS-1:0]  rsp_centre_distance
);

   localparam int ROOT_BITS = COORD_BITS + 1;

   logic                    geom_valid;
   logic                    sqrt_ready;
   logic [2*ROOT_BITS-1:0]  radicand;

   kpd_geom #(
      .COORD_BITS (COORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_geom (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .first_index   (req_first_index),
      .first_left    (req_first_left),
      .first_top     (req_first_top),
      .first_right   (req_first_right),
      .first_bottom  (req_first_bottom),
      .second_index  (req_second_index),
      .second_left   (req_second_left),
      .second_top    (req_second_top),
      .second_right  (req_second_right),
      .second_bottom (req_second_bottom),
      .out_valid     (geom_valid),
      .out_ready     (sqrt_ready),
      .out_radicand  (radicand)
   );

   kpd_sqrt #(
      .ROOT_BITS (ROOT_BITS)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (geom_valid),
      .in_ready    (sqrt_ready),
      .in_radicand (radicand),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_root    (rsp_centre_distance)
   );

   // With the result side ready, every stage advances, so the input must be ready.
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("request side stalled while the result side is ready");

   // Reset empties the whole pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A radicand held back by the square root must not change or vanish.
   assert property (@(posedge clock) disable iff (reset)
      geom_valid && !sqrt_ready |=> geom_valid && $stable(radicand))
      else $error("radicand lost or changed while stalled");

endmodule
